@@ src/heun_pkg.sv @@
// Shared types, constants and saturating helpers for the Heun ODE solver core.
// Used by heun_mul and heun_second_order_ode_solver_core; no dependencies.
package heun_pkg;

  localparam int DATA_W           = 32;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int MAX_STEPS_DEF    = 65536;
  localparam int CFG_IDX_W        = 2;

  localparam logic [CFG_IDX_W-1:0] REG_START_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_SLOPE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_H      = 2'd3;

  localparam logic signed [DATA_W-1:0] STEP_H_RESET = 32'sd6554;

  typedef logic signed [DATA_W-1:0] word_t;

  // Request to the shared multiplier; half selects the extra divide by two.
  typedef struct packed {
    logic go;
    logic half;
  } mul_req_t;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_CHECK = 11'b000_0000_0010,
    ST_M1    = 11'b000_0000_0100,
    ST_M2    = 11'b000_0000_1000,
    ST_M3    = 11'b000_0001_0000,
    ST_M4    = 11'b000_0010_0000,
    ST_M5    = 11'b000_0100_0000,
    ST_M6    = 11'b000_1000_0000,
    ST_M7    = 11'b001_0000_0000,
    ST_DONE  = 11'b010_0000_0000,
    ST_SPARE = 11'b100_0000_0000
  } state_t;

  function automatic word_t sat34(input logic signed [33:0] a);
    word_t r;
    if (a > 34'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (a < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = a[31:0];
    end
    return r;
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [33:0] s;
    s = 34'(a) + 34'(b);
    return sat34(s);
  endfunction

  // 2x - y - v, saturated
  function automatic word_t deriv2(input word_t x, input word_t y, input word_t v);
    logic signed [33:0] s;
    s = (34'(x) <<< 1) - 34'(y) - 34'(v);
    return sat34(s);
  endfunction

  // 2*|t - x| <= |h|, exact
  function automatic logic reached(input word_t x, input word_t t, input word_t h);
    logic signed [32:0] d;
    logic signed [32:0] hx;
    logic [32:0]        ad;
    logic [32:0]        ah;
    d  = 33'(t) - 33'(x);
    hx = 33'(h);
    ad = d[32] ? 33'(-d) : 33'(d);
    ah = hx[32] ? 33'(-hx) : 33'(hx);
    return {ad, 1'b0} <= {1'b0, ah};
  endfunction

endpackage

@@ src/heun_mul.sv @@
// Shared signed 32x32 multiplier with round-to-nearest and saturation to 32 bits.
// Depends on heun_pkg. Result is valid the cycle after a request.
module heun_mul import heun_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  mul_req_t req,
  input  word_t    a,
  input  word_t    b,
  output word_t    res
);

  localparam logic signed [63:0] RND_Q = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] RND_H = 64'sd1 <<< FRAC_BITS;

  logic signed [63:0] prod;
  logic               half_q;
  logic signed [63:0] shifted;

  // Rounding constant is folded into the multiply-add
  always_ff @(posedge clk) begin
    if (req.go) begin
      prod   <= 64'(a) * 64'(b) + (req.half ? RND_H : RND_Q);
      half_q <= req.half;
    end
  end

  always_comb begin
    shifted = half_q ? (prod >>> (FRAC_BITS + 1)) : (prod >>> FRAC_BITS);
    if (shifted > 64'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (shifted < -64'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = shifted[31:0];
    end
  end

endmodule

@@ src/heun_second_order_ode_solver_core.sv @@
// Heun (RK2) solver for y'' = 2x - y - y' in signed fixed point, top level.
// Depends on heun_pkg and heun_mul.
//
// Usage:
//   Write start_x, start_y, start_slope and step_h through cfg_we/cfg_index/cfg_data
//   while the core is idle. Each input item on s_tdata is a target abscissa; the
//   core steps from the start point until the abscissa lies within half a step of
//   the target or the step limit is hit, and returns one item: y on m_tdata and
//   the not-reached flag on m_tuser. A zero step or one pointing away takes no step.
// Sequencing: an accepted item passes through a check state, then any Heun steps,
//   up to MAX_STEPS of them, then the done state that loads the output register.
//   Each Heun step runs through sequencer states M1 to M7 around the one shared
//   multiplier, which carries four dependent products per step.
// Flow: one item at a time; s_tready is high only when the sequencer idles,
//   so the next item is taken only after the previous result has been loaded.
//   A finished result sits in the output register, so a new item is taken while
//   it waits.
// Reset: registers return to start 0, 0, 0 and step 6554; no item is pending.
// Stall: with m_tready low a new result waits in the sequencer until the output
//   register is free; nothing is dropped.
module heun_second_order_ode_solver_core import heun_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [DATA_W-1:0]    s_tdata,   // [31:0] target_x
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [DATA_W-1:0]    m_tdata,   // [31:0] y_at_target
  output logic                 m_tuser    // [0] not_reached
);

  localparam int CNT_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_STEPS - 1);

  word_t start_x, start_y, start_slope, step_h;
  word_t x, y, v, t;
  word_t m21, m22, yp, vp, xp, s1, s2;
  logic [CNT_W-1:0] n;
  logic             flag;
  state_t           state, state_next;

  mul_req_t mreq;
  word_t    mul_b;
  word_t    mres;

  logic  done_hit;
  logic  wrong_dir;
  logic  out_free;
  logic signed [32:0] d;

  heun_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk (clk),
    .req (mreq),
    .a   (step_h),
    .b   (mul_b),
    .res (mres)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x     <= '0;
      start_y     <= '0;
      start_slope <= '0;
      step_h      <= STEP_H_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_X:     start_x     <= cfg_data;
        REG_START_Y:     start_y     <= cfg_data;
        REG_START_SLOPE: start_slope <= cfg_data;
        REG_STEP_H:      step_h      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign done_hit = reached(x, t, step_h);
  assign d        = 33'(t) - 33'(x);
  assign wrong_dir = (step_h == '0) ||
                     ((!step_h[31]) != (!d[32] && (d != '0)));

  // Multiplier schedule
  always_comb begin
    mreq  = '{go: 1'b0, half: 1'b0};
    mul_b = v;
    unique case (state)
      ST_M1: begin
        mreq  = '{go: 1'b1, half: 1'b0};
        mul_b = v;
      end
      ST_M2: begin
        mreq  = '{go: 1'b1, half: 1'b0};
        mul_b = m21;
      end
      ST_M5: begin
        mreq  = '{go: 1'b1, half: 1'b1};
        mul_b = s1;
      end
      ST_M6: begin
        mreq  = '{go: 1'b1, half: 1'b1};
        mul_b = s2;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_CHECK;
      ST_CHECK: state_next = (done_hit || wrong_dir) ? ST_DONE : ST_M1;
      ST_M1:    state_next = ST_M2;
      ST_M2:    state_next = ST_M3;
      ST_M3:    state_next = ST_M4;
      ST_M4:    state_next = ST_M5;
      ST_M5:    state_next = ST_M6;
      ST_M6:    state_next = ST_M7;
      ST_M7:    state_next = (done_hit || (n == CNT_LAST)) ? ST_DONE : ST_M1;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        x <= start_x;
        y <= start_y;
        v <= start_slope;
        t <= s_tdata;
        n <= '0;
      end
      ST_CHECK: flag <= !done_hit;
      ST_M1: m21 <= deriv2(x, y, v);
      ST_M2: yp  <= sat_add(y, mres);
      ST_M3: begin
        vp <= sat_add(v, mres);
        xp <= sat_add(x, step_h);
      end
      ST_M4: begin
        s1  <= sat_add(v, vp);
        m22 <= deriv2(xp, yp, vp);
      end
      ST_M5: s2 <= sat_add(m21, m22);
      ST_M6: begin
        y <= sat_add(y, mres);
        x <= xp;
      end
      ST_M7: begin
        v    <= sat_add(v, mres);
        flag <= !done_hit;
        if (!done_hit && (n != CNT_LAST)) n <= n + 1'b1;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= y;
      m_tuser <= flag;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_CHECK)
    else $error("accepted item did not start the run");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && out_free |=> m_tvalid && state == ST_IDLE)
    else $error("result not moved to output register");

  a_limit_flag: assert property (@(posedge clk) disable iff (rst)
    state == ST_M7 && !done_hit && n == CNT_LAST |=> state == ST_DONE && flag)
    else $error("step limit did not end the run with flag");

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !s_tready)
    else $error("input taken while busy");

endmodule
